### hw/rtl/smd_pkg.sv
// Shared types, constants and float32 helper functions for the magnitude decimator.
`timescale 1ns / 1ps
package smd_pkg;

    localparam int MaxRow   = 4096;
    localparam int MaxGroup = 256;
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);

    localparam logic [31:0] ScaleReset   = 32'h42c8_0000;
    localparam logic [31:0] FloatNan     = 32'h7fc0_0000;
    localparam logic [31:0] FloatInf     = 32'h7f80_0000;
    localparam logic [31:0] HalfMaxFloat = 32'h477f_e000;

    typedef enum logic [2:0] {
        CFG_SCALE        = 3'd0,
        CFG_ROW_LENGTH   = 3'd1,
        CFG_FIRST_COLUMN = 3'd2,
        CFG_GROUP_SIZE   = 3'd3,
        CFG_OUTPUT_COUNT = 3'd4,
        CFG_HALF_OUTPUT  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FC_NUM  = 2'd0,
        FC_ZERO = 2'd1,
        FC_INF  = 2'd2,
        FC_NAN  = 2'd3
    } t_fcls;

    typedef struct packed {
        logic [31:0] real_bits;
        logic [31:0] imag_bits;
        logic        act;
        logic        close;
        logic        row_end;
    } t_item;

    typedef struct packed {
        logic [31:0] scale;
        logic        half;
    } t_cfg_view;

    typedef struct packed {
        logic               sign;
        t_fcls              cls;
        logic [47:0]        prod;
        logic signed [10:0] esum;
    } t_mpre;

    function automatic t_mpre fmul_pre(logic [31:0] a, logic [31:0] b);
        t_mpre       r;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [7:0]  ea1;
        logic [7:0]  eb1;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        a_z;
        logic        b_z;
        logic [23:0] ma;
        logic [23:0] mb;
        ea    = a[30:23];
        eb    = b[30:23];
        a_nan = (ea == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hff) && (b[22:0] == 23'd0);
        a_z   = (a[30:0] == 31'd0);
        b_z   = (b[30:0] == 31'd0);
        ea1   = (ea == 8'd0) ? 8'd1 : ea;
        eb1   = (eb == 8'd0) ? 8'd1 : eb;
        ma    = {ea != 8'd0, a[22:0]};
        mb    = {eb != 8'd0, b[22:0]};
        r.sign = a[31] ^ b[31];
        r.prod = ma * mb;
        r.esum = $signed({3'b000, ea1}) + $signed({3'b000, eb1}) - 11'sd126;
        if (a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z)) begin
            r.cls = FC_NAN;
        end else if (a_inf || b_inf) begin
            r.cls = FC_INF;
        end else if (a_z || b_z) begin
            r.cls = FC_ZERO;
        end else begin
            r.cls = FC_NUM;
        end
        return r;
    endfunction

    function automatic logic [31:0] fmul_post(t_mpre p);
        logic [5:0]         lz;
        logic [47:0]        pn;
        logic [47:0]        sh;
        logic [47:0]        mask;
        logic signed [11:0] e;
        logic signed [11:0] amt;
        logic [5:0]         rs;
        logic [7:0]         ef;
        logic               st;
        logic [23:0]        m;
        logic               g;
        logic               s;
        logic [24:0]        mr;
        logic [30:0]        mag;
        logic [31:0]        res;
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (p.prod[i]) lz = 6'(47 - i);
        end
        pn = p.prod << lz;
        e  = {p.esum[10], p.esum} - $signed({6'b000000, lz});
        st = 1'b0;
        sh = pn;
        ef = e[7:0];
        if (e < 12'sd1) begin
            amt  = 12'sd1 - e;
            rs   = (amt > 12'sd48) ? 6'd48 : amt[5:0];
            mask = ~({48{1'b1}} << rs);
            st   = |(pn & mask);
            sh   = pn >> rs;
            ef   = 8'd1;
        end
        m   = sh[47:24];
        g   = sh[23];
        s   = (|sh[22:0]) | st;
        mr  = {1'b0, m} + {24'd0, g & (s | m[0])};
        mag = {ef - 8'd1, 23'd0} + {6'd0, mr};
        case (p.cls)
            FC_NAN:  res = FloatNan;
            FC_INF:  res = {p.sign, FloatInf[30:0]};
            FC_ZERO: res = {p.sign, 31'd0};
            default: begin
                if (e > 12'sd254) res = {p.sign, FloatInf[30:0]};
                else res = {p.sign, mag};
            end
        endcase
        return res;
    endfunction

    // Operands are squares, so both signs are clear.
    function automatic logic [31:0] fadd_pos(logic [31:0] a, logic [31:0] b);
        logic [30:0] x;
        logic [30:0] y;
        logic [7:0]  ex1;
        logic [7:0]  ey1;
        logic [7:0]  d;
        logic [23:0] mx;
        logic [23:0] my;
        logic [49:0] ext;
        logic [49:0] sh;
        logic        so;
        logic [26:0] xa;
        logic [26:0] ya;
        logic [27:0] sum;
        logic [26:0] sn;
        logic [8:0]  e;
        logic [23:0] m;
        logic        g;
        logic        s;
        logic [24:0] mr;
        logic [30:0] mag;
        logic [31:0] res;
        if (a[30:0] < b[30:0]) begin
            x = b[30:0];
            y = a[30:0];
        end else begin
            x = a[30:0];
            y = b[30:0];
        end
        ex1 = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey1 = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d   = ex1 - ey1;
        mx  = {x[30:23] != 8'd0, x[22:0]};
        my  = {y[30:23] != 8'd0, y[22:0]};
        ext = {my, 26'd0};
        sh  = ext >> d;
        so  = |(ext & ~({50{1'b1}} << d));
        xa  = {mx, 3'b000};
        ya  = {sh[49:24], (|sh[23:0]) | so};
        sum = {1'b0, xa} + {1'b0, ya};
        if (sum[27]) begin
            sn = {sum[27:2], sum[1] | sum[0]};
            e  = {1'b0, ex1} + 9'd1;
        end else begin
            sn = sum[26:0];
            e  = {1'b0, ex1};
        end
        m   = sn[26:3];
        g   = sn[2];
        s   = |sn[1:0];
        mr  = {1'b0, m} + {24'd0, g & (s | m[0])};
        mag = {e[7:0] - 8'd1, 23'd0} + {6'd0, mr};
        if (((a[30:23] == 8'hff) && (a[22:0] != 23'd0)) ||
            ((b[30:23] == 8'hff) && (b[22:0] != 23'd0))) begin
            res = FloatNan;
        end else if ((a[30:23] == 8'hff) || (b[30:23] == 8'hff) || (e > 9'd254)) begin
            res = FloatInf;
        end else begin
            res = {1'b0, mag};
        end
        return res;
    endfunction

    function automatic logic [15:0] to_half_sat(logic [31:0] v);
        logic [31:0] c;
        logic [7:0]  e;
        logic [22:0] m;
        logic [14:0] hb;
        logic [12:0] rem;
        logic [7:0]  shf;
        logic [23:0] m24;
        logic [23:0] hs;
        logic [23:0] rs;
        logic [23:0] mid;
        logic [15:0] h;
        if (v[31] || ((v[30:23] == 8'hff) && (v[22:0] != 23'd0))) begin
            c = 32'd0;
        end else if (v[30:0] > HalfMaxFloat[30:0]) begin
            c = HalfMaxFloat;
        end else begin
            c = v;
        end
        e = c[30:23];
        m = c[22:0];
        if (c == 32'd0) begin
            h = 16'd0;
        end else if (e >= 8'd113) begin
            hb  = {5'(e - 8'd112), m[22:13]};
            rem = m[12:0];
            if ((rem > 13'h1000) || ((rem == 13'h1000) && hb[0])) h = {1'b0, hb} + 16'd1;
            else h = {1'b0, hb};
        end else begin
            shf = 8'd126 - e;
            m24 = {1'b1, m};
            hs  = m24 >> shf;
            rs  = m24 & ~({24{1'b1}} << shf);
            mid = 24'd1 << (shf - 8'd1);
            if (shf >= 8'd25) h = 16'd0;
            else if ((rs > mid) || ((rs == mid) && hs[0])) h = hs[15:0] + 16'd1;
            else h = hs[15:0];
        end
        return h;
    endfunction

endpackage

### hw/rtl/smd_if.sv
// Request channel interfaces for element input and pooled result output.
`timescale 1ns / 1ps
interface smd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] real_bits;
    logic [31:0] imag_bits;
    modport source (output valid, output real_bits, output imag_bits, input ready);
    modport sink   (input valid, input real_bits, input imag_bits, output ready);
endinterface

interface smd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        row_end;
    modport source (output valid, output value_bits, output row_end, input ready);
    modport sink   (input valid, input value_bits, input row_end, output ready);
endinterface

### hw/rtl/smd_queue.sv
// Small register FIFO between the classifying front and the arithmetic back.
`timescale 1ns / 1ps
module smd_queue
    import smd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);
    t_item            r_mem [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QPtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

### hw/rtl/smd_front.sv
// Front end: configuration registers, row and group bookkeeping, request classification.
`timescale 1ns / 1ps
module smd_front
    import smd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    smd_in_if.sink        i_in,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_q_full,
    output logic          o_push,
    output t_item         o_item,
    output t_cfg_view     o_cfg
);
    logic [31:0] r_scale;
    logic [12:0] r_row_length;
    logic [11:0] r_first_column;
    logic [8:0]  r_group_size;
    logic [12:0] r_output_count;
    logic        r_half;
    logic [11:0] r_col;
    logic [7:0]  r_fill;
    logic [12:0] r_done;

    logic [12:0] rl;
    logic [8:0]  gs;
    logic        accept;
    logic        last;
    logic        act;
    logic [8:0]  fill_inc;
    logic [12:0] done_inc;
    logic        close;

    always_comb begin
        rl = r_row_length;
        if (rl == 13'd0) rl = 13'd1;
        if (rl > 13'(MaxRow)) rl = 13'(MaxRow);
        gs = r_group_size;
        if (gs == 9'd0) gs = 9'd1;
        if (gs > 9'(MaxGroup)) gs = 9'(MaxGroup);
    end

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign last       = ({1'b0, r_col} + 13'd1) >= rl;
    assign act        = (r_col >= r_first_column) && (r_done < r_output_count);
    assign fill_inc   = {1'b0, r_fill} + 9'd1;
    assign done_inc   = r_done + 13'd1;
    assign close      = (fill_inc >= gs) || last;

    assign o_push            = accept && (act || last);
    assign o_item.real_bits  = i_in.real_bits;
    assign o_item.imag_bits  = i_in.imag_bits;
    assign o_item.act        = act;
    assign o_item.close      = act && close;
    assign o_item.row_end    = last || (done_inc == r_output_count);
    assign o_cfg.scale       = r_scale;
    assign o_cfg.half        = r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale        <= ScaleReset;
            r_row_length   <= 13'(MaxRow);
            r_first_column <= '0;
            r_group_size   <= 9'd1;
            r_output_count <= 13'(MaxRow);
            r_half         <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE:        r_scale        <= i_cfg_data;
                CFG_ROW_LENGTH:   r_row_length   <= i_cfg_data[12:0];
                CFG_FIRST_COLUMN: r_first_column <= i_cfg_data[11:0];
                CFG_GROUP_SIZE:   r_group_size   <= i_cfg_data[8:0];
                CFG_OUTPUT_COUNT: r_output_count <= i_cfg_data[12:0];
                CFG_HALF_OUTPUT:  r_half         <= i_cfg_data[0];
                default:          r_half         <= r_half;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_fill <= '0;
            r_done <= '0;
        end else if (accept) begin
            if (last) begin
                r_col  <= '0;
                r_fill <= '0;
                r_done <= '0;
            end else begin
                r_col <= r_col + 12'd1;
                if (act) begin
                    if (close) begin
                        r_fill <= '0;
                        r_done <= done_inc;
                    end else begin
                        r_fill <= fill_inc[7:0];
                    end
                end
            end
        end
    end
endmodule

### hw/rtl/smd_back.sv
// Back end: float32 squared magnitude, scaling, group maximum and result formatting.
`timescale 1ns / 1ps
module smd_back
    import smd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_item     i_head,
    output logic      o_pop,
    input  t_cfg_view i_cfg,
    smd_out_if.source o_out
);
    typedef enum logic [6:0] {
        BS_IDLE = 7'b0000001,
        BS_M1   = 7'b0000010,
        BS_M2   = 7'b0000100,
        BS_ADD  = 7'b0001000,
        BS_SC   = 7'b0010000,
        BS_M3   = 7'b0100000,
        BS_UPD  = 7'b1000000
    } t_bstate;

    t_bstate     r_state;
    t_item       r_item;
    t_mpre       r_pre;
    logic [31:0] r_rr;
    logic [31:0] r_ii;
    logic [31:0] r_sum;
    logic [31:0] r_v;
    logic [31:0] r_max;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_row_end;

    logic        v_gt;
    logic [31:0] new_max;
    logic        slot_free;
    logic        emit;

    assign v_gt      = !r_v[31] && !((r_v[30:23] == 8'hff) && (r_v[22:0] != 23'd0)) &&
                       (r_v[30:0] > r_max[30:0]);
    assign new_max   = v_gt ? r_v : r_max;
    assign slot_free = !r_out_valid || o_out.ready;
    assign emit      = (r_state == BS_UPD) && r_item.close && slot_free;
    assign o_pop     = (r_state == BS_IDLE) && !i_q_empty;

    assign o_out.valid      = r_out_valid;
    assign o_out.value_bits = r_out_value;
    assign o_out.row_end    = r_out_row_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_head;
        case (r_state)
            BS_IDLE: r_pre <= fmul_pre(i_head.real_bits, i_head.real_bits);
            BS_M1: begin
                r_rr  <= fmul_post(r_pre);
                r_pre <= fmul_pre(r_item.imag_bits, r_item.imag_bits);
            end
            BS_M2:   r_ii  <= fmul_post(r_pre);
            BS_ADD:  r_sum <= fadd_pos(r_rr, r_ii);
            BS_SC:   r_pre <= fmul_pre(r_sum, i_cfg.scale);
            BS_M3:   r_v   <= fmul_post(r_pre);
            default: r_v   <= r_v;
        endcase
        if (emit) begin
            r_out_value   <= i_cfg.half ? {16'd0, to_half_sat(new_max)} : new_max;
            r_out_row_end <= r_item.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        if (i_head.act) r_state <= BS_M1;
                        else r_max <= '0;
                    end
                end
                BS_M1:  r_state <= BS_M2;
                BS_M2:  r_state <= BS_ADD;
                BS_ADD: r_state <= BS_SC;
                BS_SC:  r_state <= BS_M3;
                BS_M3:  r_state <= BS_UPD;
                BS_UPD: begin
                    if (!r_item.close) begin
                        r_max   <= new_max;
                        r_state <= BS_IDLE;
                    end else if (slot_free) begin
                        r_max   <= '0;
                        r_state <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/spectral_magnitude_decimator.sv
// Top level: complex element stream to max-pooled scaled squared magnitudes.
//  channel | dir | handshake     | payload
//  i_in    | in  | valid/ready   | real_bits[31:0], imag_bits[31:0]
//  o_out   | out | valid/ready   | value_bits[31:0], row_end
//  cfg     | in  | i_cfg_we      | i_cfg_idx[2:0], i_cfg_data[31:0]
// An element that feeds a group passes the back-end states M1, M2, ADD, SC, M3 and UPD:
// one shared float multiplier (two stages) is used three times, plus one add and one compare step.
// Elements outside any group never enter the arithmetic states; the 4-entry queue absorbs bursts.
// Reset is synchronous and needs no clearing pass; the result register holds while stalled.
`timescale 1ns / 1ps
module spectral_magnitude_decimator
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    smd_in_if.sink      i_in,
    smd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    t_item     q_in;
    t_item     q_head;
    t_cfg_view cfg;

    smd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (q_in),
        .o_cfg      (cfg)
    );

    smd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    smd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .i_cfg     (cfg),
        .o_out     (o_out)
    );
endmodule

### hw/rtl/smd_checker.sv
// Port-level assertions for the magnitude decimator, bound to the top level.
`timescale 1ns / 1ps
module smd_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_row_end
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_row_end))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_non_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_value[31])
        else $error("pooled magnitude has sign bit set");
endmodule

bind spectral_magnitude_decimator smd_port_checker u_smd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.value_bits),
    .i_out_row_end (o_out.row_end)
);

### test/smd_checker.sv
// Checker for the magnitude decimator: predicts pooled results and compares them.
`timescale 1ns / 1ps
module smd_checker
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    smd_in_if           in_ch,
    smd_out_if          out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] value_bits;
        logic        row_end;
    } t_pooled;

    t_pooled     pending_results[$];

    logic [31:0] scale_reg;
    logic [12:0] row_length_reg;
    logic [11:0] first_column_reg;
    logic [8:0]  group_size_reg;
    logic [12:0] output_count_reg;
    logic        half_reg;

    int          column_idx;
    int          group_fill;
    logic [31:0] group_max;
    int          row_outputs;

    function automatic logic is_nan(logic [31:0] f);
        return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
    endfunction

    // Round mant * 2^exp2 to nearest even in a format with mbits stored bits.
    function automatic longint round_fp(logic [127:0] mant, int exp2, int mbits, int bias);
        int           p;
        int           biased;
        int           sh;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] tie;
        longint       r;
        if (mant == 128'd0) return 0;
        p = 0;
        for (int i = 0; i < 128; i++) begin
            if (mant[i]) p = i;
        end
        biased = p + exp2 + bias;
        sh = (biased >= 1) ? p - mbits : (1 - bias - mbits) - exp2;
        if (sh <= 0) begin
            q = mant << (-sh);
        end else if (sh >= 120) begin
            return 0;
        end else begin
            q   = mant >> sh;
            rem = mant & ((128'd1 << sh) - 128'd1);
            tie = 128'd1 << (sh - 1);
            if (rem > tie || (rem == tie && q[0])) q = q + 128'd1;
        end
        r = (biased >= 1) ? (longint'(biased - 1) << mbits) : 0;
        return r + longint'(q[62:0]);
    endfunction

    function automatic logic [31:0] mul_single(logic [31:0] a, logic [31:0] b);
        logic   s;
        logic   inf_a;
        logic   inf_b;
        logic   zero_a;
        logic   zero_b;
        longint r;
        s      = a[31] ^ b[31];
        inf_a  = (a[30:0] == 31'h7f80_0000);
        inf_b  = (b[30:0] == 31'h7f80_0000);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b) || (inf_a && zero_b) || (inf_b && zero_a)) return FloatNan;
        if (inf_a || inf_b) return {s, FloatInf[30:0]};
        if (zero_a || zero_b) return {s, 31'd0};
        r = round_fp(128'({a[30:23] != 8'd0, a[22:0]}) * 128'({b[30:23] != 8'd0, b[22:0]}),
                     ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150 +
                     ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150, 23, 127);
        if (r >= longint'(FloatInf)) r = longint'(FloatInf);
        return {s, r[30:0]};
    endfunction

    // Both operands are squares: sign clear or NaN.
    function automatic logic [31:0] add_squares(logic [31:0] a, logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        int          xh;
        int          xl;
        int          d;
        longint      r;
        if (is_nan(a) || is_nan(b)) return FloatNan;
        if (a[30:23] == 8'hff || b[30:23] == 8'hff) return FloatInf;
        if (a[30:23] >= b[30:23]) begin
            hi = a;
            lo = b;
        end else begin
            hi = b;
            lo = a;
        end
        xh = ((hi[30:23] == 8'd0) ? 1 : int'(hi[30:23])) - 150;
        xl = ((lo[30:23] == 8'd0) ? 1 : int'(lo[30:23])) - 150;
        d  = xh - xl;
        if (d > 80) return {1'b0, hi[30:0]};
        r = round_fp((128'({hi[30:23] != 8'd0, hi[22:0]}) << d) +
                     128'({lo[30:23] != 8'd0, lo[22:0]}), xl, 23, 127);
        if (r >= longint'(FloatInf)) r = longint'(FloatInf);
        return {1'b0, r[30:0]};
    endfunction

    function automatic logic [15:0] clamp_to_half(logic [31:0] v);
        longint r;
        if (is_nan(v) || v[31]) return 16'd0;
        if (v[30:0] > HalfMaxFloat[30:0]) v = HalfMaxFloat;
        r = round_fp(128'({v[30:23] != 8'd0, v[22:0]}),
                     ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150, 10, 15);
        return r[15:0];
    endfunction

    task automatic pool_element(logic [31:0] re, logic [31:0] im);
        int          rl;
        int          gs;
        logic        last;
        logic [31:0] power;
        t_pooled     res;
        rl = (row_length_reg == 0) ? 1 : (row_length_reg > MaxRow) ? MaxRow : row_length_reg;
        gs = (group_size_reg == 0) ? 1 : (group_size_reg > MaxGroup) ? MaxGroup : group_size_reg;
        last = (column_idx + 1 >= rl);
        if (column_idx >= first_column_reg && row_outputs < output_count_reg) begin
            power = mul_single(add_squares(mul_single(re, re), mul_single(im, im)), scale_reg);
            if (!is_nan(power) && !power[31] && power[30:0] > group_max[30:0]) group_max = power;
            group_fill++;
            if (group_fill >= gs || last) begin
                row_outputs++;
                res.value_bits = half_reg ? {16'd0, clamp_to_half(group_max)} : group_max;
                res.row_end    = last || (row_outputs == output_count_reg);
                pending_results.push_back(res);
                group_fill = 0;
                group_max  = 32'd0;
            end
        end
        if (last) begin
            column_idx  = 0;
            group_fill  = 0;
            group_max   = 32'd0;
            row_outputs = 0;
        end else begin
            column_idx++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pooled want;
        if (!i_rst_n) begin
            scale_reg        = ScaleReset;
            row_length_reg   = 13'd4096;
            first_column_reg = 12'd0;
            group_size_reg   = 9'd1;
            output_count_reg = 13'd4096;
            half_reg         = 1'b1;
            column_idx       = 0;
            group_fill       = 0;
            group_max        = 32'd0;
            row_outputs      = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SCALE:        scale_reg        = i_cfg_data;
                    CFG_ROW_LENGTH:   row_length_reg   = i_cfg_data[12:0];
                    CFG_FIRST_COLUMN: first_column_reg = i_cfg_data[11:0];
                    CFG_GROUP_SIZE:   group_size_reg   = i_cfg_data[8:0];
                    CFG_OUTPUT_COUNT: output_count_reg = i_cfg_data[12:0];
                    CFG_HALF_OUTPUT:  half_reg         = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result value_bits=%h row_end=%b",
                           out_ch.value_bits, out_ch.row_end);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.value_bits !== want.value_bits) begin
                        $error("value_bits expected %h actual %h",
                               want.value_bits, out_ch.value_bits);
                        o_fail_count++;
                    end
                    if (out_ch.row_end !== want.row_end) begin
                        $error("row_end expected %b actual %b", want.row_end, out_ch.row_end);
                        o_fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) pool_element(in_ch.real_bits, in_ch.imag_bits);
        end
        o_pending = pending_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
    end

endmodule

### test/tb_spectral_magnitude_decimator.sv
// Testbench top: stimulus, register settings, flow control and verdict for the decimator.
`timescale 1ns / 1ps
module tb_spectral_magnitude_decimator;
    import smd_pkg::*;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we  = 1'b0;
    logic [2:0]  cfg_idx = 3'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;
    int          idle_mode = 0;
    int          elements_sent = 0;
    int          settings_used = 0;
    int          fail_count;
    int          pending;
    int          results;

    smd_in_if  in_ch();
    smd_out_if out_ch();

    always #5 i_clk = ~i_clk;

    spectral_magnitude_decimator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    smd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 400;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (idle_mode == 2) begin
            out_ch.ready <= ($urandom_range(99) >= 75);
        end else if (idle_mode == 3) begin
            out_ch.ready <= ($urandom_range(99) >= 14);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #20_000_000;
        $display("[spectral_magnitude_decimator] ERROR");
        $finish;
    end

    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return {1'($urandom), 8'($urandom_range(140, 100)), 23'($urandom)};
            7: return {1'($urandom), 8'($urandom_range(20, 0)), 23'($urandom)};
            8: begin
                case ($urandom_range(4))
                    0: return {1'($urandom), 31'd0};
                    1: return {1'($urandom), FloatInf[30:0]};
                    2: return {1'($urandom), 8'hff, 23'($urandom) | 23'd1};
                    3: return {1'($urandom), 8'd0, 23'($urandom)};
                    default: return 32'h7f7f_ffff;
                endcase
            end
            default: return {1'($urandom), 8'($urandom_range(135, 118)), 23'($urandom) & 23'h7f_e000};
        endcase
    endfunction

    function automatic logic [31:0] random_scale();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'd0;
            2: return {1'b1, 8'($urandom_range(135, 110)), 23'($urandom)};
            default: return {1'b0, 8'($urandom_range(135, 110)), 23'($urandom)};
        endcase
    endfunction

    task automatic put_reg(t_cfg_idx idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(logic [31:0] scale, logic [31:0] rows, logic [31:0] first,
                                 logic [31:0] group, logic [31:0] count, logic [31:0] half);
        put_reg(CFG_SCALE, scale);
        put_reg(CFG_ROW_LENGTH, rows);
        put_reg(CFG_FIRST_COLUMN, first);
        put_reg(CFG_GROUP_SIZE, group);
        put_reg(CFG_OUTPUT_COUNT, count);
        put_reg(CFG_HALF_OUTPUT, half);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_element(logic [31:0] re, logic [31:0] im);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 75 : (idle_mode == 3) ? 14 : 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.real_bits <= re;
        in_ch.imag_bits <= im;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        elements_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic random_phase(int mode, int n_items, logic long_hold);
        idle_mode = mode;
        if (long_hold) begin
            hold_req <= 1'b1;
            @(posedge i_clk);
            hold_req <= 1'b0;
        end
        for (int i = 0; i < n_items; i++) send_element(random_operand(), random_operand());
        drain();
    endtask

    initial begin
        int rows;
        int phase;
        in_ch.valid     <= 1'b0;
        in_ch.real_bits <= 32'd0;
        in_ch.imag_bits <= 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: scale 100, one column per group, half output
        send_element(32'h0000_0000, 32'h0000_0000);
        send_element(32'h8000_0000, 32'h8000_0000);
        send_element(32'h3f80_0000, 32'h0000_0000);
        send_element(32'h0000_0000, 32'hbf80_0000);
        send_element(32'h7f7f_ffff, 32'h0000_0000);
        send_element(32'h7f80_0000, 32'h0000_0000);
        send_element(32'hff80_0000, 32'h3f80_0000);
        send_element(32'h7fc0_0000, 32'h0000_0000);
        send_element(32'h7f80_0001, 32'h3f80_0000);
        send_element(32'h0000_0001, 32'h0000_0001);
        send_element(32'h0040_0000, 32'h0000_0000);
        send_element(32'h3dcc_cccd, 32'h3dcc_cccd);
        send_element(32'h41c8_0000, 32'h0000_0000);
        send_element(32'h41cc_0000, 32'h0000_0000);
        send_element(32'h41cd_0000, 32'h0000_0000);
        send_element(32'h3a80_0000, 32'h0000_0000);
        send_element(32'h3380_0000, 32'h0000_0000);
        send_element(32'hffff_ffff, 32'hffff_ffff);
        send_element(32'h5f80_0000, 32'h5f80_0000);
        send_element(32'h3f80_0001, 32'hbf7f_ffff);
        drain();

        load_settings(32'h3f80_0000, 8, 0, 1, 8, 0);
        random_phase(0, 32, 1'b0);
        load_settings(ScaleReset, 37, 5, 4, 20, 1);
        random_phase(1, 74, 1'b0);
        load_settings(random_scale(), 1, 0, 256, 1, 1);
        random_phase(2, 20, 1'b0);
        load_settings(32'h3f80_0000, 0, 0, 0, 0, 0);
        random_phase(3, 10, 1'b0);
        load_settings(32'h3f80_0000, 1, 0, 0, 8191, 0);
        random_phase(0, 12, 1'b0);
        load_settings(ScaleReset, 8191, 4095, 511, 8191, 1);
        random_phase(1, 30, 1'b0);
        load_settings(32'h3c23_d70a, 16, 3, 2, 3, 0);
        random_phase(0, 64, 1'b1);
        load_settings(32'h7f80_0000, 12, 0, 3, 4096, 1);
        random_phase(3, 36, 1'b0);
        load_settings(32'hbf80_0000, 10, 0, 2, 5, 0);
        random_phase(2, 20, 1'b0);
        load_settings(32'h4780_0000, 9, 0, 9, 1, 1);
        random_phase(0, 27, 1'b0);

        phase = 0;
        while (elements_sent < 1020) begin
            rows = $urandom_range(40, 1);
            load_settings(random_scale(),
                          rows,
                          ($urandom_range(4) == 0) ? $urandom_range(rows + 4) :
                              $urandom_range(rows / 4),
                          ($urandom_range(5) == 0) ? $urandom_range(511) : $urandom_range(rows, 1),
                          ($urandom_range(3) == 0) ? $urandom_range(rows, 0) : 4096,
                          $urandom_range(1));
            random_phase(phase % 4, rows * $urandom_range(4, 1), (phase % 9) == 4);
            phase++;
        end

        $display("Streamed %0d complex elements through %0d register settings;",
                 elements_sent, settings_used);
        $display("%0d pooled results compared, %0d mismatches.", results, fail_count);
        if (fail_count == 0) begin
            $display("[spectral_magnitude_decimator] OK");
        end else begin
            $display("[spectral_magnitude_decimator] ERROR");
        end
        $finish;
    end

endmodule
